// ===== hw/rtl/rmc_pkg.sv =====
package rmc_pkg;

	// request codes
	localparam logic [1:0] REQ_POST  = 2'd0;
	localparam logic [1:0] REQ_BUILD = 2'd1;
	localparam logic [1:0] REQ_RECV  = 2'd2;
	localparam logic [1:0] REQ_TICK  = 2'd3;

	// configuration register indexes
	localparam logic [0:0] REG_MAX_PENDING   = 1'd0;
	localparam logic [0:0] REG_TIMEOUT_TICKS = 1'd1;

	localparam logic [15:0] MAX_PENDING_RST   = 16'd1024;
	localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd10000;
	localparam logic [31:0] MAX_QUEUE         = 32'd65535;
	localparam logic [15:0] HALF_SEQ          = 16'd32767;

	// sequence map entries; slot is the low sequence bits, so a power of two
	localparam int SEQ_WINDOW = 64;

	// controller to datapath commands
	typedef struct packed {
		logic start;     // latch request, do the work that needs no map read
		logic map_rd;    // issue read of ack slot
		logic ack_eval;  // evaluate hit with read data
		logic clr_step;  // clear one map entry at clr index
		logic finish;    // finish recv part, load output word
	} rmc_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_recv;
		logic ack_hit;
		logic clr_last;
	} rmc_sts_t;

	// 16-bit wrap-around "a newer than b"; exactly half-way apart is newer
	// only when a is numerically below b
	function automatic logic newer_seq(input logic [15:0] a, input logic [15:0] b);
		logic [15:0] d;
		d = a - b;
		return (d != 16'd0) && ((d <= HALF_SEQ) || ((d == HALF_SEQ + 16'd1) && (a < b)));
	endfunction

endpackage

// ===== hw/rtl/rmc_ctrl.sv =====
module rmc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              out_busy,
	input  rmc_pkg::rmc_sts_t sts,
	output rmc_pkg::rmc_cmd_t cmd,
	output logic              idle
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DECO  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_EVAL  = 3'd3;
	localparam logic [2:0] ST_CLEAR = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd.start = 1'b1;
					state_d = ST_DECO;
				end
			end
			ST_DECO: begin
				if (sts.is_recv) begin
					cmd.map_rd = 1'b1;
					state_d = ST_READ;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_READ: begin
				cmd.ack_eval = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: state_d = sts.ack_hit ? ST_CLEAR : ST_DONE;
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_busy) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign idle = (state_q == ST_IDLE);

endmodule

// ===== hw/rtl/rmc_dp.sv =====
module rmc_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  rmc_pkg::rmc_cmd_t cmd,
	output rmc_pkg::rmc_sts_t sts,
	input  logic [1:0]        req_type,
	input  logic [15:0]       ack_in,
	input  logic              rel_present_in,
	input  logic [15:0]       seq_in,
	input  logic [31:0]       first_msg_in,
	input  logic [15:0]       count_in,
	input  logic [15:0]       max_pending,
	input  logic [31:0]       timeout_ticks,
	output logic              out_load,
	output logic              accepted,
	output logic              rel_section,
	output logic [15:0]       packet_sequence,
	output logic [15:0]       packet_ack_sequence,
	output logic [31:0]       packet_first_msg,
	output logic [15:0]       packet_msg_count,
	output logic [15:0]       ack_out,
	output logic [31:0]       skip_count,
	output logic              timeout_flag
);

	localparam int AW = (rmc_pkg::SEQ_WINDOW > 1) ? $clog2(rmc_pkg::SEQ_WINDOW) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(rmc_pkg::SEQ_WINDOW - 1);

	// sender / receiver state
	logic [15:0] send_seq_q, acked_seq_q, recv_seq_q;
	logic [31:0] first_pend_q, next_id_q, recv_msg_q, idle_q;
	logic        ack_flag_q;
	logic [rmc_pkg::SEQ_WINDOW-1:0] map_vld_q;

	// sequence map: tag and message id in a memory, valid bits in flops
	logic [47:0] map_mem [rmc_pkg::SEQ_WINDOW];
	logic [47:0] rd_data_q;
	logic [AW-1:0] clr_idx_q;

	// latched request
	logic [1:0]  req_q;
	logic [15:0] ack_q, seq_q, cnt_q;
	logic        rel_q, hit_q;
	logic [31:0] first_q;

	logic [31:0] pend;
	assign pend = next_id_q - first_pend_q;

	logic [AW-1:0] ack_slot, send_slot;
	logic [15:0]   send_next;
	assign ack_slot  = ack_q[AW-1:0];
	assign send_next = send_seq_q + 16'd1;
	assign send_slot = send_next[AW-1:0];

	// hit check on registered read data
	logic        hit;
	logic [31:0] rec_msg, rel_ofs;
	assign rec_msg = rd_data_q[31:0];
	assign rel_ofs = rec_msg - first_pend_q;
	assign hit = rmc_pkg::newer_seq(ack_q, acked_seq_q) && map_vld_q[ack_slot]
		&& (rd_data_q[47:32] == ack_q);

	// clear sweep: entry tag inside acked..ack (acked_seq_q still old)
	logic [15:0] span, tag_d;
	logic [15:0] map_mem_tag;
	logic [47:0] clr_rd_q;
	assign map_mem_tag = clr_rd_q[47:32];
	assign span  = ack_q - acked_seq_q + 16'd1;
	assign tag_d = map_mem_tag - acked_seq_q;

	assign sts.is_recv  = (req_q == rmc_pkg::REQ_RECV);
	assign sts.ack_hit  = hit_q;
	assign sts.clr_last = (clr_idx_q == LAST_IDX);

	// memory write on build, reads for ack slot and sweep
	logic build_wr;
	assign build_wr = cmd.start && (req_type == rmc_pkg::REQ_BUILD) && (pend != 32'd0);
	always_ff @(posedge clk) begin
		if (build_wr) map_mem[send_slot] <= {send_next, next_id_q};
		if (cmd.map_rd) rd_data_q <= map_mem[ack_slot];
		clr_rd_q <= map_mem[cmd.clr_step ? AW'(clr_idx_q + 1'b1) : '0];
	end

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= req_type;
			ack_q <= ack_in;
			rel_q <= rel_present_in;
			seq_q <= seq_in;
			first_q <= first_msg_in;
			cnt_q <= count_in;
		end
	end

	// output word fields computed at start (post/build) or finish (recv)
	logic        acc_q, hr_q;
	logic [15:0] pseq_q, pack_q, pcnt_q;
	logic [31:0] pfirst_q, skip_q;

	logic recv_new;
	assign recv_new = rel_q && rmc_pkg::newer_seq(seq_q, recv_seq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_seq_q <= '0; acked_seq_q <= '0; recv_seq_q <= '0;
			first_pend_q <= '0; next_id_q <= '0; recv_msg_q <= '0;
			idle_q <= '0; ack_flag_q <= 1'b0; map_vld_q <= '0;
			hit_q <= 1'b0; clr_idx_q <= '0;
			acc_q <= 1'b0; hr_q <= 1'b0; pseq_q <= '0; pack_q <= '0;
			pcnt_q <= '0; pfirst_q <= '0; skip_q <= '0;
		end else begin
			if (cmd.start) begin
				acc_q <= 1'b0; hr_q <= 1'b0; pseq_q <= '0; pack_q <= '0;
				pcnt_q <= '0; pfirst_q <= '0; skip_q <= '0;
				clr_idx_q <= '0;
				case (req_type)
					rmc_pkg::REQ_POST: begin
						if (pend < rmc_pkg::MAX_QUEUE) begin
							next_id_q <= next_id_q + 32'd1;
							acc_q <= 1'b1;
						end
					end
					rmc_pkg::REQ_BUILD: begin
						if (pend != 32'd0) begin
							send_seq_q <= send_next;
							map_vld_q[send_slot] <= 1'b1;
							hr_q <= 1'b1;
							pseq_q <= send_next;
							pack_q <= acked_seq_q;
							pfirst_q <= first_pend_q;
							pcnt_q <= pend[15:0];
						end
						ack_flag_q <= 1'b0;
					end
					rmc_pkg::REQ_RECV: idle_q <= '0;
					default: if (idle_q != '1) idle_q <= idle_q + 32'd1;
				endcase
			end
			if (cmd.ack_eval) begin
				hit_q <= hit;
				if (hit) begin
					first_pend_q <= (rel_ofs > pend) ? next_id_q : rec_msg;
				end
			end
			// one entry a cycle; clr_rd_q holds entry clr_idx_q
			if (cmd.clr_step) begin
				if (map_vld_q[clr_idx_q] && (tag_d < span)) map_vld_q[clr_idx_q] <= 1'b0;
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == LAST_IDX) acked_seq_q <= ack_q;
			end
			if (cmd.finish && sts.is_recv) begin
				hit_q <= 1'b0;
				if (recv_new) begin
					recv_seq_q <= seq_q;
					ack_flag_q <= 1'b1;
					acc_q <= 1'b1;
					skip_q <= recv_msg_q - first_q;
					recv_msg_q <= first_q + {16'd0, cnt_q};
				end
			end
		end
	end

	// finish uses live state for ack and timeout
	logic [15:0] ack_now;
	assign ack_now = (sts.is_recv && recv_new) ? seq_q : recv_seq_q;

	assign out_load            = cmd.finish;
	assign accepted            = acc_q | (sts.is_recv && recv_new);
	assign rel_section         = hr_q;
	assign packet_sequence     = pseq_q;
	assign packet_ack_sequence = pack_q;
	assign packet_first_msg    = pfirst_q;
	assign packet_msg_count    = pcnt_q;
	assign ack_out             = ack_now;
	assign skip_count          = (sts.is_recv && recv_new) ? (recv_msg_q - first_q) : skip_q;
	assign timeout_flag        = (pend > {16'd0, max_pending}) || (idle_q >= timeout_ticks);

endmodule

// ===== hw/rtl/reliable_message_channel_unit.sv =====
// Reliable message channel bookkeeping (sender and receiver counters).
// Input channel: valid/ready with req_type and packet fields, one word per item.
// Output channel: valid/ready, exactly one result word per accepted item.
// APB port: register 0 max_pending at 0x0, register 1 timeout_ticks at 0x4.
// Post, build and tick go from the accept through the decode and done states to
// the output register; an incoming packet adds a map read and a hit check, and
// on an acknowledgement hit the map clearing sweep of one entry per cycle.
// One item is in flight at a time; ready is high only while the controller
// is idle, so a new item is not taken while the last is still in progress.
// Reset clears all counters, marks every map entry invalid and loads the
// register defaults (1024, 10000). No clearing pass is needed after reset.
// If the receiver stalls, the result waits in the output register and the
// next item is taken but held before its final step until the word leaves.
module reliable_message_channel_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [1:0]  req_type,
	input  logic [15:0] ack_in,
	input  logic        rel_present_in,
	input  logic [15:0] seq_in,
	input  logic [31:0] first_msg_in,
	input  logic [15:0] count_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic        rel_section,
	output logic [15:0] packet_sequence,
	output logic [15:0] packet_ack_sequence,
	output logic [31:0] packet_first_msg,
	output logic [15:0] packet_msg_count,
	output logic [15:0] ack_out,
	output logic [31:0] skip_count,
	output logic        timeout_flag,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] max_pend_q;
	logic [31:0] tmo_q;
	logic        idle, out_load;
	rmc_pkg::rmc_cmd_t cmd;
	rmc_pkg::rmc_sts_t sts;

	// configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pend_q <= rmc_pkg::MAX_PENDING_RST;
			tmo_q <= rmc_pkg::TIMEOUT_TICKS_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == rmc_pkg::REG_MAX_PENDING) max_pend_q <= pwdata[15:0];
			else tmo_q <= pwdata;
		end
	end
	assign prdata = (paddr[2] == rmc_pkg::REG_MAX_PENDING) ? {16'd0, max_pend_q} : tmo_q;

	assign ready = idle;

	logic out_busy;
	assign out_busy = out_valid && !out_ready;

	rmc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(valid && ready), .out_busy(out_busy),
		.sts(sts), .cmd(cmd), .idle(idle)
	);

	logic        w_acc, w_hr, w_to;
	logic [15:0] w_pseq, w_pack, w_pcnt, w_ack;
	logic [31:0] w_pfirst, w_skip;

	rmc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_type(req_type), .ack_in(ack_in), .rel_present_in(rel_present_in),
		.seq_in(seq_in), .first_msg_in(first_msg_in), .count_in(count_in),
		.max_pending(max_pend_q), .timeout_ticks(tmo_q), .out_load(out_load),
		.accepted(w_acc), .rel_section(w_hr), .packet_sequence(w_pseq),
		.packet_ack_sequence(w_pack), .packet_first_msg(w_pfirst),
		.packet_msg_count(w_pcnt), .ack_out(w_ack), .skip_count(w_skip),
		.timeout_flag(w_to)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (out_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (out_load) begin
			accepted <= w_acc; rel_section <= w_hr; packet_sequence <= w_pseq;
			packet_ack_sequence <= w_pack; packet_first_msg <= w_pfirst;
			packet_msg_count <= w_pcnt; ack_out <= w_ack;
			skip_count <= w_skip; timeout_flag <= w_to;
		end
	end

endmodule

// ===== hw/rtl/rmc_checker.sv =====
module rmc_props (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input logic ready,
	input logic out_valid,
	input logic out_ready,
	input logic rel_section,
	input logic [15:0] packet_msg_count,
	input logic accepted
);

	// output word holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("output word dropped");

	// one item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready |=> !ready) else $error("second item taken while busy");

	// a built packet with reliable section carries messages
	a_build_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rel_section |-> packet_msg_count != 16'd0)
		else $error("empty reliable section");

	// a packet header word never reports acceptance
	a_build_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rel_section |-> !accepted) else $error("build flagged accepted");

endmodule

bind reliable_message_channel_unit rmc_props u_rmc_props (
	.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
	.out_valid(out_valid), .out_ready(out_ready), .rel_section(rel_section),
	.packet_msg_count(packet_msg_count), .accepted(accepted)
);

// ===== bench/rmc_checker.sv =====
module rmc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	input  logic        ready,
	input  logic [1:0]  req_type,
	input  logic [15:0] ack_in,
	input  logic        rel_present_in,
	input  logic [15:0] seq_in,
	input  logic [31:0] first_msg_in,
	input  logic [15:0] count_in,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        accepted,
	input  logic        rel_section,
	input  logic [15:0] packet_sequence,
	input  logic [15:0] packet_ack_sequence,
	input  logic [31:0] packet_first_msg,
	input  logic [15:0] packet_msg_count,
	input  logic [15:0] ack_out,
	input  logic [31:0] skip_count,
	input  logic        timeout_flag,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SEQ_WINDOW = rmc_pkg::SEQ_WINDOW;

	typedef struct packed {
		logic        accepted;
		logic        rel_section;
		logic [15:0] packet_sequence;
		logic [15:0] packet_ack_sequence;
		logic [31:0] packet_first_msg;
		logic [15:0] packet_msg_count;
		logic [15:0] ack_out;
		logic [31:0] skip_count;
		logic        timeout_flag;
	} chan_word_t;

	// shadow of channel state
	logic [15:0] cfg_max_pending;
	logic [31:0] cfg_timeout;
	logic [15:0] tx_seq, tx_acked;
	logic [31:0] tx_first, tx_next;
	logic        map_vld[SEQ_WINDOW];
	logic [15:0] map_tag[SEQ_WINDOW];
	logic [31:0] map_msg[SEQ_WINDOW];
	logic [15:0] rx_seq;
	logic [31:0] rx_msg;
	logic [31:0] idle_cnt;
	chan_word_t  expected_words[$];

	// half-way apart is newer only when a is numerically below b
	function automatic logic seq_after(logic [15:0] a, logic [15:0] b);
		logic [15:0] d;
		d = a - b;
		return (d != 16'd0) && ((d <= 16'd32767) || ((d == 16'h8000) && (a < b)));
	endfunction

	// release acknowledged messages and sweep the acked map range
	function automatic void apply_ack(input logic [15:0] ack);
		int unsigned slot;
		logic [31:0] rel;
		logic [15:0] span, d;
		if (!seq_after(ack, tx_acked))
			return;
		slot = ack % SEQ_WINDOW;
		if (!map_vld[slot] || map_tag[slot] != ack)
			return;
		rel = map_msg[slot] - tx_first;
		if (rel > tx_next - tx_first)
			tx_first = tx_next;
		else
			tx_first = map_msg[slot];
		span = ack - tx_acked + 16'd1;
		for (int i = 0; i < SEQ_WINDOW; i++) begin
			d = map_tag[i] - tx_acked;
			if (map_vld[i] && d < span)
				map_vld[i] = 1'b0;
		end
		tx_acked = ack;
	endfunction

	function automatic chan_word_t predict_word(input logic [1:0] req, input logic [15:0] ack,
			input logic rel_in, input logic [15:0] seq, input logic [31:0] first,
			input logic [15:0] cnt);
		chan_word_t w;
		logic [31:0] p;
		int unsigned slot;
		w = '0;
		case (req)
			rmc_pkg::REQ_POST: begin
				if (tx_next - tx_first < rmc_pkg::MAX_QUEUE) begin
					tx_next++;
					w.accepted = 1'b1;
				end
			end
			rmc_pkg::REQ_BUILD: begin
				p = tx_next - tx_first;
				if (p != 0) begin
					tx_seq++;
					slot = tx_seq % SEQ_WINDOW;
					w.rel_section = 1'b1;
					w.packet_sequence = tx_seq;
					w.packet_ack_sequence = tx_acked;
					w.packet_first_msg = tx_first;
					w.packet_msg_count = p[15:0];
					map_vld[slot] = 1'b1;
					map_tag[slot] = tx_seq;
					map_msg[slot] = tx_next;
				end
			end
			rmc_pkg::REQ_RECV: begin
				idle_cnt = 0;
				apply_ack(ack);
				if (rel_in && seq_after(seq, rx_seq)) begin
					rx_seq = seq;
					w.accepted = 1'b1;
					w.skip_count = rx_msg - first;
					rx_msg = first + 32'(cnt);
				end
			end
			default: begin
				if (idle_cnt != 32'hFFFF_FFFF)
					idle_cnt++;
			end
		endcase
		w.ack_out = rx_seq;
		w.timeout_flag = ((tx_next - tx_first) > 32'(cfg_max_pending)) || (idle_cnt >= cfg_timeout);
		return w;
	endfunction

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		chan_word_t e;
		if (!arst_n) begin
			cfg_timeout = rmc_pkg::TIMEOUT_TICKS_RST;
			cfg_max_pending = rmc_pkg::MAX_PENDING_RST;
			tx_seq = '0; tx_acked = '0; tx_first = '0; tx_next = '0;
			rx_seq = '0; rx_msg = '0; idle_cnt = '0;
			for (int i = 0; i < SEQ_WINDOW; i++) begin
				map_vld[i] = 1'b0; map_tag[i] = '0; map_msg[i] = '0;
			end
			expected_words.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == rmc_pkg::REG_TIMEOUT_TICKS)
					cfg_timeout = pwdata;
				else
					cfg_max_pending = pwdata[15:0];
			end
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("result word with no expectation waiting");
					fail_count++;
				end else begin
					e = expected_words.pop_front();
					if (accepted !== e.accepted) begin
						$error("accepted exp %0h got %0h", e.accepted, accepted); fail_count++;
					end
					if (rel_section !== e.rel_section) begin
						$error("rel_section exp %0h got %0h", e.rel_section, rel_section);
						fail_count++;
					end
					if (packet_sequence !== e.packet_sequence) begin
						$error("packet_sequence exp %0h got %0h", e.packet_sequence,
							packet_sequence);
						fail_count++;
					end
					if (packet_ack_sequence !== e.packet_ack_sequence) begin
						$error("packet_ack_sequence exp %0h got %0h", e.packet_ack_sequence,
							packet_ack_sequence);
						fail_count++;
					end
					if (packet_first_msg !== e.packet_first_msg) begin
						$error("packet_first_msg exp %0h got %0h", e.packet_first_msg,
							packet_first_msg);
						fail_count++;
					end
					if (packet_msg_count !== e.packet_msg_count) begin
						$error("packet_msg_count exp %0h got %0h", e.packet_msg_count,
							packet_msg_count);
						fail_count++;
					end
					if (ack_out !== e.ack_out) begin
						$error("ack_out exp %0h got %0h", e.ack_out, ack_out); fail_count++;
					end
					if (skip_count !== e.skip_count) begin
						$error("skip_count exp %0h got %0h", e.skip_count,
							skip_count);
						fail_count++;
					end
					if (timeout_flag !== e.timeout_flag) begin
						$error("timeout_flag exp %0h got %0h", e.timeout_flag, timeout_flag);
						fail_count++;
					end
				end
			end
			if (valid && ready)
				expected_words.insert(expected_words.size(), predict_word(req_type, ack_in,
					rel_present_in, seq_in, first_msg_in, count_in));
		end
		outstanding = expected_words.size();
	end
endmodule

// ===== bench/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk, arst_n;
	logic        valid, ready;
	logic [1:0]  req_type;
	logic [15:0] ack_in, seq_in, count_in;
	logic        rel_present_in;
	logic [31:0] first_msg_in;
	logic        out_valid, out_ready;
	logic        accepted, rel_section, timeout_flag;
	logic [15:0] packet_sequence, packet_ack_sequence, packet_msg_count, ack_out;
	logic [31:0] packet_first_msg, skip_count;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	int          fail_count, outstanding;
	int          cycle_count = 0;
	bit          calm;       // no idling in the last part
	bit          hold_off;   // request for a long receiver stall
	bit          hold_done;

	// model of the far end's view, used to aim acks and sequences
	logic [15:0] sent_seq, far_seq;
	logic [31:0] far_msg;

	reliable_message_channel_unit DUT (.*);

	rmc_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: random stalls plus one long hold-off
	initial begin
		int n;
		out_ready = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off && !hold_done) begin
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 13);
				out_ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else
				out_ready <= 1'b1;
		end
	end

	task automatic reg_write(input logic [0:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// offer one word, hold until taken; valid stays up for a following word
	task automatic send_word(input logic [1:0] req, input logic [15:0] ack, input logic rel,
			input logic [15:0] seq, input logic [31:0] first, input logic [15:0] cnt);
		int n;
		if (!calm && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 13);
			valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		valid <= 1'b1; req_type <= req; ack_in <= ack; rel_present_in <= rel;
		seq_in <= seq; first_msg_in <= first; count_in <= cnt;
		@(posedge clk);
		while (!ready) @(posedge clk);
		@(negedge clk);
		if (req == rmc_pkg::REQ_BUILD) sent_seq++;
	endtask

	task automatic drain_idle();
		valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// random word, mostly well formed traffic
	task automatic random_word();
		int k;
		logic [15:0] ack, cnt;
		logic [31:0] first;
		k = $urandom_range(0, 99);
		if (k < 35)
			send_word(rmc_pkg::REQ_POST, 16'($urandom), 1'($urandom), 16'($urandom),
				$urandom, 16'($urandom));
		else if (k < 55)
			send_word(rmc_pkg::REQ_BUILD, 16'($urandom), 1'($urandom), 16'($urandom),
				$urandom, 16'($urandom));
		else if (k < 85) begin
			ack = ($urandom_range(0, 3) == 0) ? 16'($urandom)
				: sent_seq - 16'($urandom_range(0, 70));
			cnt = 16'($urandom_range(0, 20));
			first = far_msg - $urandom_range(0, 8);
			far_seq = far_seq + 16'($urandom_range(1, 3));
			if ($urandom_range(0, 4) == 0) begin
				send_word(rmc_pkg::REQ_RECV, ack, 1'($urandom), 16'($urandom), $urandom,
					16'($urandom));
			end else begin
				send_word(rmc_pkg::REQ_RECV, ack, 1'b1, far_seq, first, cnt);
				far_msg = first + cnt;
			end
		end else
			send_word(rmc_pkg::REQ_TICK, 16'($urandom), 1'($urandom), 16'($urandom),
				$urandom, 16'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		valid = 1'b0; req_type = rmc_pkg::REQ_POST; ack_in = '0; rel_present_in = 1'b0;
		seq_in = '0; first_msg_in = '0; count_in = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		calm = 1'b0; hold_off = 1'b0;
		sent_seq = '0; far_seq = '0; far_msg = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: tiny limits so timeouts show up
		reg_write(rmc_pkg::REG_MAX_PENDING, 32'd0);
		reg_write(rmc_pkg::REG_TIMEOUT_TICKS, 32'd1);
		send_word(rmc_pkg::REQ_BUILD, '0, 1'b0, '0, '0, '0);   // nothing pending
		send_word(rmc_pkg::REQ_TICK, '0, 1'b0, '0, '0, '0);
		send_word(rmc_pkg::REQ_POST, 16'hFFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(rmc_pkg::REQ_POST, '0, 1'b0, '0, '0, '0);
		send_word(rmc_pkg::REQ_BUILD, '0, 1'b0, '0, '0, '0);
		send_word(rmc_pkg::REQ_POST, '0, 1'b0, '0, '0, '0);
		send_word(rmc_pkg::REQ_BUILD, '0, 1'b0, '0, '0, '0);
		send_word(rmc_pkg::REQ_RECV, 16'd5, 1'b0, '0, '0, '0);      // ack miss
		send_word(rmc_pkg::REQ_RECV, 16'd1, 1'b1, 16'd1, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(rmc_pkg::REQ_RECV, 16'd2, 1'b1, 16'h8001, 32'd0, 16'd0); // too far
		send_word(rmc_pkg::REQ_RECV, 16'd1, 1'b1, 16'd1, 32'd3, 16'd1);   // stale
		send_word(rmc_pkg::REQ_RECV, 16'hFFFF, 1'b1, 16'hFFFF, '0, '0);
		drain_idle();
		reg_write(rmc_pkg::REG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
		reg_write(rmc_pkg::REG_MAX_PENDING, 32'h0000_FFFF);
		repeat (3) send_word(rmc_pkg::REQ_TICK, '0, 1'b0, '0, '0, '0);
		far_seq = 16'hFFFF;
		far_msg = '0;

		// random phases with changing limits
		for (int ph = 0; ph < 5; ph++) begin
			drain_idle();
			reg_write(rmc_pkg::REG_MAX_PENDING, $urandom_range(0, 40));
			reg_write(rmc_pkg::REG_TIMEOUT_TICKS, (ph == 4) ? 32'd0 : $urandom_range(1, 30));
			if (ph == 1) hold_off = 1'b1;
			if (ph == 4) calm = 1'b1;
			for (int i = 0; i < 210; i++) random_word();
		end

		// wait for everything to come back
		drain_idle();
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
